[rtl/clle_pkg.sv]
// Shared types and codes for the cursor linked-list engine.
// No dependencies; imported by the top level.
package clle_pkg;

  localparam int SLOT_COUNT_DEF = 256;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [3:0] FN_CREATE    = 4'd0;
  localparam logic [3:0] FN_INS_HEAD  = 4'd1;
  localparam logic [3:0] FN_INS_AFTER = 4'd2;
  localparam logic [3:0] FN_FIND      = 4'd3;
  localparam logic [3:0] FN_DELETE    = 4'd4;
  localparam logic [3:0] FN_EMPTY     = 4'd5;
  localparam logic [3:0] FN_IS_EMPTY  = 4'd6;
  localparam logic [3:0] FN_IS_LAST   = 4'd7;
  localparam logic [3:0] FN_READ      = 4'd8;

  typedef struct packed {
    logic [3:0]         func;
    logic [7:0]         list_head;
    logic [7:0]         position;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [7:0]         result_pos;
    logic signed [31:0] result_value;
    logic               flag;
    logic               status;
  } out_word_t;

endpackage

[rtl/clle_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the link and value stores.
module clle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/cursor_linked_list_engine.sv]
// Cursor linked-list engine top level; uses clle_pkg and clle_ram.
// Create and inserts take a free slot or report out of space; find walks the list node by
// node, delete too with extra link writes on removal, and empty list returns each node to
// the free list. Non-power-of-two SLOT_COUNT below 256 adds a slot-reduction pass.
// One word at a time; the next is taken while the last result waits at the output.
// Reset starts a free-list build; in_ready stays low until it ends.
module cursor_linked_list_engine #(
  parameter int SLOT_COUNT = clle_pkg::SLOT_COUNT_DEF,
  parameter int VALUE_BITS = clle_pkg::VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  clle_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output clle_pkg::out_word_t out_data
);
  import clle_pkg::*;

  localparam int SB     = $clog2(SLOT_COUNT);
  localparam int STEP_W = SB + 1;
  localparam logic [SB-1:0]     LAST_SLOT = SB'(SLOT_COUNT - 1);
  localparam logic [STEP_W-1:0] STEP_MAX  = STEP_W'(SLOT_COUNT);
  localparam bit NEED_RED = (SLOT_COUNT < 256) && ((SLOT_COUNT & (SLOT_COUNT - 1)) != 0);
  localparam logic [8:0] RED_LIM = 9'(SLOT_COUNT);

  localparam logic [4:0] ST_INIT  = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_RED   = 5'd2;
  localparam logic [4:0] ST_DISP  = 5'd3;
  localparam logic [4:0] ST_AL_B  = 5'd4;
  localparam logic [4:0] ST_AL_C  = 5'd5;
  localparam logic [4:0] ST_CR_D  = 5'd6;
  localparam logic [4:0] ST_IN_D  = 5'd7;
  localparam logic [4:0] ST_IN_E  = 5'd8;
  localparam logic [4:0] ST_IN_F  = 5'd9;
  localparam logic [4:0] ST_FD_B  = 5'd10;
  localparam logic [4:0] ST_FD_C  = 5'd11;
  localparam logic [4:0] ST_DL_B  = 5'd12;
  localparam logic [4:0] ST_DL_C  = 5'd13;
  localparam logic [4:0] ST_DL_W1 = 5'd14;
  localparam logic [4:0] ST_DL_W2 = 5'd15;
  localparam logic [4:0] ST_DL_W3 = 5'd16;
  localparam logic [4:0] ST_EM_B  = 5'd17;
  localparam logic [4:0] ST_EM_C  = 5'd18;
  localparam logic [4:0] ST_EM_D  = 5'd19;
  localparam logic [4:0] ST_EM_E  = 5'd20;
  localparam logic [4:0] ST_EM_F  = 5'd21;
  localparam logic [4:0] ST_TST   = 5'd22;
  localparam logic [4:0] ST_RD    = 5'd23;
  localparam logic [4:0] ST_FIN   = 5'd24;

  logic [4:0]            state_r, state_nxt;
  logic [SB-1:0]         idx_r, idx_nxt;
  logic [3:0]            func_r, func_nxt;
  logic [7:0]            head_raw_r, head_raw_nxt;
  logic [7:0]            pos_raw_r, pos_raw_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [SB-1:0]         cur_r, cur_nxt;
  logic [SB-1:0]         prev_r, prev_nxt;
  logic [SB-1:0]         ln_r, ln_nxt;
  logic [SB-1:0]         fh_r, fh_nxt;
  logic [STEP_W-1:0]     steps_r, steps_nxt;
  logic [SB-1:0]         res_pos_r, res_pos_nxt;
  logic [31:0]           res_val_r, res_val_nxt;
  logic                  res_flag_r, res_flag_nxt;
  logic                  res_status_r, res_status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_data_r, out_data_nxt;

  logic                  lk_we, vl_we, rd_en;
  logic [SB-1:0]         lk_waddr, lk_wdata, rd_addr;
  logic [SB-1:0]         lk_q;
  logic [VALUE_BITS-1:0] vl_q;
  logic [SB-1:0]         head_s, pos_s, ins_p;
  logic                  head_big, pos_big;

  clle_ram #(.WIDTH(SB), .DEPTH(SLOT_COUNT)) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (lk_q)
  );

  clle_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOT_COUNT)) u_value_ram (
    .clk   (clk),
    .we    (vl_we),
    .waddr (cur_r),
    .wdata (val_r),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (vl_q)
  );

  assign head_s   = SB'(head_raw_r);
  assign pos_s    = SB'(pos_raw_r);
  assign ins_p    = (func_r == FN_INS_HEAD) ? head_s : pos_s;
  assign head_big = {1'b0, head_raw_r} >= RED_LIM;
  assign pos_big  = {1'b0, pos_raw_r} >= RED_LIM;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    func_nxt       = func_r;
    head_raw_nxt   = head_raw_r;
    pos_raw_nxt    = pos_raw_r;
    val_nxt        = val_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    ln_nxt         = ln_r;
    fh_nxt         = fh_r;
    steps_nxt      = steps_r;
    res_pos_nxt    = res_pos_r;
    res_val_nxt    = res_val_r;
    res_flag_nxt   = res_flag_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    lk_we          = 1'b0;
    lk_waddr       = '0;
    lk_wdata       = '0;
    vl_we          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_INIT: begin
        lk_we    = 1'b1;
        lk_waddr = idx_r;
        lk_wdata = (idx_r == LAST_SLOT) ? '0 : idx_r + SB'(1);
        idx_nxt  = idx_r + SB'(1);
        if (idx_r == LAST_SLOT) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt     = in_data.func;
          head_raw_nxt = in_data.list_head;
          pos_raw_nxt  = in_data.position;
          val_nxt      = VALUE_BITS'($unsigned(in_data.value));
          state_nxt    = NEED_RED ? ST_RED : ST_DISP;
        end
      end
      ST_RED: begin
        if (head_big) begin
          head_raw_nxt = head_raw_r - 8'(SLOT_COUNT);
        end
        if (pos_big) begin
          pos_raw_nxt = pos_raw_r - 8'(SLOT_COUNT);
        end
        if (!head_big && !pos_big) begin
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        res_pos_nxt    = '0;
        res_val_nxt    = '0;
        res_flag_nxt   = 1'b0;
        res_status_nxt = 1'b0;
        steps_nxt      = '0;
        rd_en          = 1'b1;
        case (func_r)
          FN_CREATE, FN_INS_HEAD, FN_INS_AFTER: begin
            rd_addr   = '0;
            state_nxt = ST_AL_B;
          end
          FN_FIND: begin
            rd_addr   = head_s;
            state_nxt = ST_FD_B;
          end
          FN_DELETE: begin
            rd_addr   = head_s;
            prev_nxt  = head_s;
            state_nxt = ST_DL_B;
          end
          FN_EMPTY: begin
            rd_addr   = '0;
            state_nxt = ST_EM_B;
          end
          FN_IS_EMPTY: begin
            rd_addr   = head_s;
            state_nxt = ST_TST;
          end
          FN_IS_LAST: begin
            rd_addr   = pos_s;
            state_nxt = ST_TST;
          end
          FN_READ: begin
            rd_addr   = pos_s;
            state_nxt = ST_RD;
          end
          default: begin
            rd_en     = 1'b0;
            state_nxt = ST_FIN;
          end
        endcase
      end
      ST_AL_B: begin
        if (lk_q == '0) begin
          res_status_nxt = 1'b1;
          state_nxt      = ST_FIN;
        end else begin
          cur_nxt   = lk_q;
          rd_en     = 1'b1;
          rd_addr   = lk_q;
          state_nxt = ST_AL_C;
        end
      end
      ST_AL_C: begin
        lk_we       = 1'b1;
        lk_waddr    = '0;
        lk_wdata    = lk_q;
        res_pos_nxt = cur_r;
        state_nxt   = (func_r == FN_CREATE) ? ST_CR_D : ST_IN_D;
      end
      ST_CR_D: begin
        lk_we     = 1'b1;
        lk_waddr  = cur_r;
        lk_wdata  = '0;
        state_nxt = ST_FIN;
      end
      ST_IN_D: begin
        rd_en     = 1'b1;
        rd_addr   = ins_p;
        state_nxt = ST_IN_E;
      end
      ST_IN_E: begin
        lk_we     = 1'b1;
        lk_waddr  = cur_r;
        lk_wdata  = lk_q;
        vl_we     = 1'b1;
        state_nxt = ST_IN_F;
      end
      ST_IN_F: begin
        lk_we     = 1'b1;
        lk_waddr  = ins_p;
        lk_wdata  = cur_r;
        state_nxt = ST_FIN;
      end
      ST_FD_B, ST_DL_B: begin
        if (lk_q == '0) begin
          state_nxt = ST_FIN;
        end else begin
          cur_nxt   = lk_q;
          rd_en     = 1'b1;
          rd_addr   = lk_q;
          state_nxt = (state_r == ST_FD_B) ? ST_FD_C : ST_DL_C;
        end
      end
      ST_FD_C, ST_DL_C: begin
        if (vl_q == val_r) begin
          if (state_r == ST_FD_C) begin
            res_pos_nxt  = cur_r;
            res_flag_nxt = 1'b1;
            state_nxt    = ST_FIN;
          end else if (prev_r != '0) begin
            ln_nxt    = lk_q;
            state_nxt = ST_DL_W1;
          end else begin
            state_nxt = ST_FIN;
          end
        end else if (steps_r == STEP_MAX || lk_q == '0) begin
          state_nxt = ST_FIN;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = lk_q;
          steps_nxt = steps_r + STEP_W'(1);
          rd_en     = 1'b1;
          rd_addr   = lk_q;
        end
      end
      ST_DL_W1: begin
        lk_we     = 1'b1;
        lk_waddr  = prev_r;
        lk_wdata  = ln_r;
        rd_en     = 1'b1;
        rd_addr   = '0;
        state_nxt = ST_DL_W2;
      end
      ST_DL_W2: begin
        lk_we     = 1'b1;
        lk_waddr  = cur_r;
        lk_wdata  = lk_q;
        state_nxt = ST_DL_W3;
      end
      ST_DL_W3: begin
        lk_we        = 1'b1;
        lk_waddr     = '0;
        lk_wdata     = cur_r;
        res_pos_nxt  = cur_r;
        res_flag_nxt = 1'b1;
        state_nxt    = ST_FIN;
      end
      ST_EM_B: begin
        fh_nxt    = lk_q;
        rd_en     = 1'b1;
        rd_addr   = head_s;
        state_nxt = ST_EM_C;
      end
      ST_EM_C: begin
        cur_nxt  = lk_q;
        lk_we    = 1'b1;
        lk_waddr = head_s;
        lk_wdata = '0;
        if (head_s == '0) begin
          fh_nxt = '0;
        end
        state_nxt = ST_EM_D;
      end
      ST_EM_D: begin
        if (cur_r == '0 || steps_r == STEP_MAX) begin
          state_nxt = ST_EM_F;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = cur_r;
          state_nxt = ST_EM_E;
        end
      end
      ST_EM_E: begin
        lk_we     = 1'b1;
        lk_waddr  = cur_r;
        lk_wdata  = fh_r;
        fh_nxt    = cur_r;
        cur_nxt   = lk_q;
        steps_nxt = steps_r + STEP_W'(1);
        state_nxt = ST_EM_D;
      end
      ST_EM_F: begin
        lk_we     = 1'b1;
        lk_waddr  = '0;
        lk_wdata  = fh_r;
        state_nxt = ST_FIN;
      end
      ST_TST: begin
        res_flag_nxt = (lk_q == '0);
        state_nxt    = ST_FIN;
      end
      ST_RD: begin
        res_val_nxt = 32'(vl_q);
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.result_pos   = 8'(res_pos_r);
          out_data_nxt.result_value = res_val_r;
          out_data_nxt.flag         = res_flag_r;
          out_data_nxt.status       = res_status_r;
          state_nxt                 = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    head_raw_r   <= head_raw_nxt;
    pos_raw_r    <= pos_raw_nxt;
    val_r        <= val_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    ln_r         <= ln_nxt;
    fh_r         <= fh_nxt;
    steps_r      <= steps_nxt;
    res_pos_r    <= res_pos_nxt;
    res_val_r    <= res_val_nxt;
    res_flag_r   <= res_flag_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

`ifndef ASSERT_OFF
  a_init_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input taken during free-list build");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");
  a_oos_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.result_pos == 8'd0 && !out_data.flag)
    else $error("out-of-space result carries a slot or flag");
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && out_valid && !out_ready |=> state_r == ST_FIN)
    else $error("result overwrote pending output word");
`endif

endmodule
